// ----- src/tq_pkg.sv -----
// shared types, codes and helpers for the ticket queue
package tq_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int TICKET_BITS  = 16;
  localparam int IDX_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int NAME_BYTES   = 19;
  localparam int GENDER_BYTES = 9;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_SERVE    = 2'd1;
  localparam logic [1:0] ACT_FIND     = 2'd2;
  localparam logic [1:0] ACT_IGNORED  = 2'd3;

  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_SERVED     = 3'd1;
  localparam logic [2:0] ST_FOUND      = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  typedef struct packed {
    logic [63:0]            name_a;
    logic [63:0]            name_b;
    logic [23:0]            name_c;
    logic [63:0]            gender_a;
    logic [7:0]             gender_b;
    logic [7:0]             age;
    logic [TICKET_BITS-1:0] ticket;
  } entry_t;

  typedef struct packed {
    logic rotate;
    logic load;
  } cell_ctrl_t;

  // a string ends at its first zero byte; everything after reads as zero
  function automatic logic [8*NAME_BYTES-1:0] cut_name(input logic [8*NAME_BYTES-1:0] w);
    logic [8*NAME_BYTES-1:0] r;
    logic                    keep;
    r    = w;
    keep = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (r[8*i +: 8] == 8'd0) keep = 1'b0;
      if (!keep) r[8*i +: 8] = 8'd0;
    end
    return r;
  endfunction

  function automatic logic [8*GENDER_BYTES-1:0] cut_gender(
      input logic [8*GENDER_BYTES-1:0] w);
    logic [8*GENDER_BYTES-1:0] r;
    logic                      keep;
    r    = w;
    keep = 1'b1;
    for (int i = 0; i < GENDER_BYTES; i++) begin
      if (r[8*i +: 8] == 8'd0) keep = 1'b0;
      if (!keep) r[8*i +: 8] = 8'd0;
    end
    return r;
  endfunction

endpackage

// ----- src/tq_cell.sv -----
// one queue cell: holds an entry, loads a new one or takes its neighbor's
module tq_cell (
  input  logic               clk,
  input  tq_pkg::cell_ctrl_t ctrl,
  input  tq_pkg::entry_t     nbr,
  input  tq_pkg::entry_t     load_d,
  output tq_pkg::entry_t     q
);
  import tq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_d;
    end else if (ctrl.rotate) begin
      q <= nbr;
    end
  end

endmodule

// ----- src/ticket_queue_with_name_search.sv -----
// top level of the ticket queue: control, ticket counter and ring of cells
//
// Command interface: an item is taken at a clock edge with start high and
// busy low. Each item of action register, serve or find yields one result,
// shown for a single cycle with done high; action 3 yields none.
// Entries sit in a ring of cells with the head in cell 0. Register loads the
// cell just past the tail and answers in the next cycle (done is registered,
// busy stays low). Serve reads cells 0 and 1, rotates the ring one step and
// also answers in the next cycle. Find rotates the whole ring through cell 0,
// comparing one entry a cycle, and keeps busy high through the whole pass;
// done comes at the end of the pass and the ring ends where it began.
// Register and serve items can follow one another with no gap; a find item
// holds off new items until its result, set by the single compare at cell 0.
// Reset empties the queue and sets the next ticket to 1; cell contents are
// left as they are. The receiver cannot hold results off: done and the result
// ports are valid for exactly one cycle.
module ticket_queue_with_name_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  action,
  input  logic [63:0] name_bytes_a,
  input  logic [63:0] name_bytes_b,
  input  logic [23:0] name_bytes_c,
  input  logic [63:0] gender_bytes_a,
  input  logic [7:0]  gender_bytes_b,
  input  logic [7:0]  age_in,
  output logic [2:0]  status,
  output logic [15:0] ticket_out,
  output logic [5:0]  ahead_count,
  output logic        next_valid,
  output logic [15:0] next_ticket,
  output logic [7:0]  age_out,
  output logic [63:0] gender_out_a,
  output logic [7:0]  gender_out_b,
  output logic [63:0] name_out_a,
  output logic [63:0] name_out_b,
  output logic [23:0] name_out_c
);
  import tq_pkg::*;

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [TICKET_BITS-1:0]  tick_ctr;
  logic [IDX_W-1:0]        step;
  logic                    found;
  logic [8*NAME_BYTES-1:0] key;

  entry_t                  cells    [QUEUE_DEPTH];
  cell_ctrl_t              cell_ctrl[QUEUE_DEPTH];
  entry_t                  new_entry;

  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic [8*NAME_BYTES-1:0] key_in;
  logic [8*GENDER_BYTES-1:0] gender_in;
  logic                    rotate;
  logic                    load_en;
  logic                    head_hit;
  logic                    last_step;
  logic [TICKET_BITS-1:0]  tick_next;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign is_full   = (count >= CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count == '0);
  assign key_in    = cut_name({name_bytes_c, name_bytes_b, name_bytes_a});
  assign gender_in = cut_gender({gender_bytes_b, gender_bytes_a});
  assign last_step = (step == IDX_W'(QUEUE_DEPTH - 1));
  assign tick_next = (tick_ctr == '1) ? TICKET_BITS'(1) : tick_ctr + TICKET_BITS'(1);

  assign new_entry.name_a   = key_in[63:0];
  assign new_entry.name_b   = key_in[127:64];
  assign new_entry.name_c   = key_in[151:128];
  assign new_entry.gender_a = gender_in[63:0];
  assign new_entry.gender_b = gender_in[71:64];
  assign new_entry.age      = age_in;
  assign new_entry.ticket   = tick_ctr;

  assign load_en = accept && (action == ACT_REGISTER) && !is_full;
  assign rotate  = (accept && (action == ACT_SERVE) && !is_empty) || (state == S_SEARCH);

  // first match from the head wins; only occupied positions take part
  assign head_hit = !found && (CNT_W'(step) < count) &&
                    ({cells[0].name_c, cells[0].name_b, cells[0].name_a} == key);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].rotate = rotate;
    assign cell_ctrl[i].load   = load_en && (count == CNT_W'(i));

    tq_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl[i]),
      .nbr   (cells[(i + 1) % QUEUE_DEPTH]),
      .load_d(new_entry),
      .q     (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      tick_ctr <= TICKET_BITS'(1);
      step     <= '0;
      found    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && action != ACT_IGNORED) begin
            status       <= ST_REGISTERED;
            ticket_out   <= '0;
            ahead_count  <= '0;
            next_valid   <= 1'b0;
            next_ticket  <= '0;
            age_out      <= '0;
            gender_out_a <= '0;
            gender_out_b <= '0;
            name_out_a   <= '0;
            name_out_b   <= '0;
            name_out_c   <= '0;
            unique case (action)
              ACT_REGISTER: begin
                done <= 1'b1;
                if (is_full) begin
                  status <= ST_FULL;
                end else begin
                  ticket_out <= 16'(tick_ctr);
                  count      <= count + CNT_W'(1);
                  tick_ctr   <= tick_next;
                end
              end
              ACT_SERVE: begin
                done <= 1'b1;
                if (is_empty) begin
                  status <= ST_EMPTY;
                end else begin
                  status     <= ST_SERVED;
                  ticket_out <= 16'(cells[0].ticket);
                  name_out_a <= cells[0].name_a;
                  name_out_b <= cells[0].name_b;
                  name_out_c <= cells[0].name_c;
                  if (count > CNT_W'(1)) begin
                    next_valid  <= 1'b1;
                    next_ticket <= 16'(cells[1].ticket);
                  end
                  count <= count - CNT_W'(1);
                end
              end
              default: begin
                status <= ST_NOT_FOUND;
                key    <= key_in;
                step   <= '0;
                found  <= 1'b0;
                state  <= S_SEARCH;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (head_hit) begin
            found        <= 1'b1;
            status       <= ST_FOUND;
            ticket_out   <= 16'(cells[0].ticket);
            ahead_count  <= 6'(step);
            age_out      <= cells[0].age;
            gender_out_a <= cells[0].gender_a;
            gender_out_b <= cells[0].gender_b;
            name_out_a   <= cells[0].name_a;
            name_out_b   <= cells[0].name_b;
            name_out_c   <= cells[0].name_c;
          end
          if (last_step) begin
            step  <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ticket_nonzero: assert property (@(posedge clk) disable iff (rst)
    tick_ctr != '0)
    else $error("ticket counter reached zero");

  a_search_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("search ended without a result");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (step == '0))
    else $error("search step not cleared while idle");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CNT_W'(QUEUE_DEPTH)))
    else $error("full reported while queue not full");
`endif

endmodule

// ----- sim/tq_reply_checker.sv -----
// result checker for the ticket queue: watches items and results, predicts and compares
`timescale 1ns / 1ps

module tq_reply_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           done,
  input  logic [1:0]                     action,
  input  logic [63:0]                    name_bytes_a,
  input  logic [63:0]                    name_bytes_b,
  input  logic [23:0]                    name_bytes_c,
  input  logic [63:0]                    gender_bytes_a,
  input  logic [7:0]                     gender_bytes_b,
  input  logic [7:0]                     age_in,
  input  logic [2:0]                     status,
  input  logic [15:0]                    ticket_out,
  input  logic [5:0]                     ahead_count,
  input  logic                           next_valid,
  input  logic [15:0]                    next_ticket,
  input  logic [7:0]                     age_out,
  input  logic [63:0]                    gender_out_a,
  input  logic [7:0]                     gender_out_b,
  input  logic [63:0]                    name_out_a,
  input  logic [63:0]                    name_out_b,
  input  logic [23:0]                    name_out_c,
  output int                             mismatch_count,
  output int                             replies_due,
  output int                             replies_checked,
  output int                             queue_level,
  output logic [tq_pkg::TICKET_BITS-1:0] ticket_next
);
  import tq_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] ticket;
    logic [5:0]  ahead;
    logic        nxt_valid;
    logic [15:0] nxt_ticket;
    logic [7:0]  age;
    logic [63:0] gender_a;
    logic [7:0]  gender_b;
    logic [63:0] name_a;
    logic [63:0] name_b;
    logic [23:0] name_c;
  } reply_t;

  entry_t ring [QUEUE_DEPTH];
  int     head_slot;
  reply_t pending_replies [$];

  initial begin
    mismatch_count  = 0;
    replies_due     = 0;
    replies_checked = 0;
    queue_level     = 0;
    head_slot       = 0;
    ticket_next     = TICKET_BITS'(1);
  end

  // bytes from the first zero byte on are dropped
  function automatic logic [151:0] trim_bytes(input logic [151:0] w, input int nbytes);
    logic [151:0] r;
    bit           ended;
    r     = '0;
    ended = 0;
    for (int i = 0; i < nbytes; i++) begin
      if (w[8*i +: 8] == 8'd0) ended = 1;
      if (!ended) r[8*i +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

  task automatic predict_reply();
    reply_t       r;
    entry_t       e;
    logic [151:0] key;
    logic [151:0] g;
    int           s;
    bit           hit;
    r   = '0;
    hit = 0;
    key = trim_bytes({name_bytes_c, name_bytes_b, name_bytes_a}, NAME_BYTES);
    case (action)
      ACT_REGISTER: begin
        if (queue_level >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          g = trim_bytes({80'd0, gender_bytes_b, gender_bytes_a}, GENDER_BYTES);
          e.name_a   = key[63:0];
          e.name_b   = key[127:64];
          e.name_c   = key[151:128];
          e.gender_a = g[63:0];
          e.gender_b = g[71:64];
          e.age      = age_in;
          e.ticket   = ticket_next;
          ring[(head_slot + queue_level) % QUEUE_DEPTH] = e;
          queue_level++;
          r.status = ST_REGISTERED;
          r.ticket = ticket_next;
          // ticket zero is never handed out
          ticket_next = (ticket_next == '1) ? TICKET_BITS'(1)
                                            : ticket_next + TICKET_BITS'(1);
        end
      end
      ACT_SERVE: begin
        if (queue_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = ring[head_slot];
          r.status = ST_SERVED;
          r.ticket = e.ticket;
          r.name_a = e.name_a;
          r.name_b = e.name_b;
          r.name_c = e.name_c;
          if (queue_level > 1) begin
            r.nxt_valid  = 1'b1;
            r.nxt_ticket = ring[(head_slot + 1) % QUEUE_DEPTH].ticket;
          end
          head_slot = (head_slot + 1) % QUEUE_DEPTH;
          queue_level--;
        end
      end
      ACT_FIND: begin
        for (int i = 0; i < queue_level; i++) begin
          s = (head_slot + i) % QUEUE_DEPTH;
          if (!hit && {ring[s].name_c, ring[s].name_b, ring[s].name_a} == key) begin
            hit        = 1;
            r.status   = ST_FOUND;
            r.ticket   = ring[s].ticket;
            r.ahead    = 6'(i);
            r.age      = ring[s].age;
            r.gender_a = ring[s].gender_a;
            r.gender_b = ring[s].gender_b;
            r.name_a   = ring[s].name_a;
            r.name_b   = ring[s].name_b;
            r.name_c   = ring[s].name_c;
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      default: return;  // ignored action, no result
    endcase
    pending_replies.push_back(r);
  endtask

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      head_slot   = 0;
      queue_level = 0;
      ticket_next = TICKET_BITS'(1);
      pending_replies.delete();
    end else begin
      if (start && !busy) predict_reply();
      if ($isunknown(done)) begin
        $error("done: expected 0 or 1, got %b", done);
        mismatch_count++;
      end else if (done) begin
        if (pending_replies.size() == 0) begin
          $error("result with no item waiting: status %0d ticket %0d", status, ticket_out);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("ticket_out", 64'(want.ticket), 64'(ticket_out));
          check_field("ahead_count", 64'(want.ahead), 64'(ahead_count));
          check_field("next_valid", 64'(want.nxt_valid), 64'(next_valid));
          check_field("next_ticket", 64'(want.nxt_ticket), 64'(next_ticket));
          check_field("age_out", 64'(want.age), 64'(age_out));
          check_field("gender_out_a", want.gender_a, gender_out_a);
          check_field("gender_out_b", 64'(want.gender_b), 64'(gender_out_b));
          check_field("name_out_a", want.name_a, name_out_a);
          check_field("name_out_b", want.name_b, name_out_b);
          check_field("name_out_c", 64'(want.name_c), 64'(name_out_c));
          replies_checked++;
        end
      end
    end
    replies_due = pending_replies.size();
  end

endmodule

// ----- sim/tb_ticket_queue_with_name_search.sv -----
// testbench top for the ticket queue: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_ticket_queue_with_name_search;
  import tq_pkg::*;

  localparam int         POOL_SIZE   = 16;
  localparam int         RANDOM_ITEMS = 800;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  logic [1:0]  action;
  logic [63:0] name_bytes_a;
  logic [63:0] name_bytes_b;
  logic [23:0] name_bytes_c;
  logic [63:0] gender_bytes_a;
  logic [7:0]  gender_bytes_b;
  logic [7:0]  age_in;
  logic [2:0]  status;
  logic [15:0] ticket_out;
  logic [5:0]  ahead_count;
  logic        next_valid;
  logic [15:0] next_ticket;
  logic [7:0]  age_out;
  logic [63:0] gender_out_a;
  logic [7:0]  gender_out_b;
  logic [63:0] name_out_a;
  logic [63:0] name_out_b;
  logic [23:0] name_out_c;

  int                     mismatch_count;
  int                     replies_due;
  int                     replies_checked;
  int                     queue_level;
  logic [TICKET_BITS-1:0] ticket_next;

  logic took;  // item taken at the last rising edge

  logic [151:0] name_pool [POOL_SIZE];
  int           name_len  [POOL_SIZE];
  bit           burst;
  int           sent_by_action [4];
  int           random_sent;

  ticket_queue_with_name_search uut (.*);

  tq_reply_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) took <= start && !busy && !rst;

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [151:0] random_name();
    logic [159:0] w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return w[151:0];
  endfunction

  // pool name, optionally with junk after its terminating zero
  function automatic logic [151:0] spell_name(input int idx, input bit noisy);
    logic [151:0] w;
    w = name_pool[idx];
    if (noisy)
      for (int i = name_len[idx] + 1; i < NAME_BYTES; i++)
        w[8*i +: 8] = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic logic [71:0] pick_gender();
    logic [95:0] g;
    g = {$urandom, $urandom, $urandom};
    if ($urandom_range(1)) g[8*$urandom_range(GENDER_BYTES-1) +: 8] = 8'd0;
    return g[71:0];
  endfunction

  function automatic logic [151:0] pick_key();
    if ($urandom_range(9) < 7)
      return spell_name($urandom_range(POOL_SIZE-1), 1'($urandom_range(1)));
    return random_name();
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic [1:0] act, input logic [151:0] nm,
                           input logic [71:0] gd, input logic [7:0] ag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action         = act;
    name_bytes_a   = nm[63:0];
    name_bytes_b   = nm[127:64];
    name_bytes_c   = nm[151:128];
    gender_bytes_a = gd[63:0];
    gender_bytes_b = gd[71:64];
    age_in         = ag;
    start          = 1'b1;
    @(negedge clk);
    while (!took) @(negedge clk);
    sent_by_action[act]++;
  endtask

  task automatic register_item(input logic [151:0] nm);
    send_item(ACT_REGISTER, nm, pick_gender(), 8'($urandom_range(255)));
  endtask

  task automatic serve_item();
    send_item(ACT_SERVE, random_name(), pick_gender(), 8'($urandom_range(255)));
  endtask

  task automatic find_item(input logic [151:0] nm);
    send_item(ACT_FIND, nm, pick_gender(), 8'($urandom_range(255)));
  endtask

  task automatic mixed_run(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 40)
        register_item(($urandom_range(99) < 85) ? spell_name($urandom_range(POOL_SIZE-1),
                                                             1'($urandom_range(1)))
                                                 : random_name());
      else if (r < 65) serve_item();
      else if (r < 95) find_item(pick_key());
      else send_item(ACT_IGNORED, random_name(), pick_gender(), 8'($urandom_range(255)));
      random_sent++;
    end
  endtask

  initial begin
    logic [151:0] last_name;
    int           kind;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_REGISTER;
    name_bytes_a = '0;
    name_bytes_b = '0;
    name_bytes_c = '0;
    gender_bytes_a = '0;
    gender_bytes_b = '0;
    age_in = '0;
    burst = 0;
    random_sent = 0;
    for (int i = 0; i < 4; i++) sent_by_action[i] = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      name_len[i] = (i == 0) ? 0 : (i == 1) ? NAME_BYTES : (i == 2) ? 5
                  : $urandom_range(NAME_BYTES, 1);
      name_pool[i] = '0;
      for (int b = 0; b < name_len[i]; b++)
        name_pool[i][8*b +: 8] = 8'($urandom_range(255, 1));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty queue, extreme fields, strings cut at a zero byte
    serve_item();
    find_item(spell_name(1, 0));
    send_item(ACT_REGISTER, {152{1'b1}}, {72{1'b1}}, 8'hFF);
    send_item(ACT_REGISTER, '0, '0, 8'h00);
    send_item(ACT_REGISTER, spell_name(2, 1), {8'hA5, 56'h1234_5600_0000_00, 8'h4D}, 8'd42);
    send_item(ACT_REGISTER, {152{1'b1}}, 72'h0, 8'd7);
    find_item({152{1'b1}});
    find_item(random_name() << 8);
    find_item(spell_name(2, 1));
    find_item(random_name());
    send_item(ACT_IGNORED, random_name(), pick_gender(), 8'($urandom_range(255)));
    repeat (5) serve_item();

    for (int i = 0; i < 10; i++) register_item(spell_name(4 + i, 1'($urandom_range(1))));
    find_item(spell_name(12, 0));
    find_item(spell_name(5, 1));
    repeat (4) serve_item();

    // random episodes: fill to full, drain to empty, or mixed traffic
    while (random_sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(3) == 0);
      kind  = $urandom_range(99);
      if (kind < 15) begin
        while (queue_level < QUEUE_DEPTH - 1) begin
          register_item(spell_name($urandom_range(POOL_SIZE-1), 1'($urandom_range(1))));
          random_sent++;
        end
        last_name = random_name();
        register_item(last_name);
        repeat ($urandom_range(3, 1)) register_item(random_name());
        find_item(last_name);
        find_item(pick_key());
        random_sent += 3;
      end else if (kind < 30) begin
        while (queue_level > 0) begin
          serve_item();
          random_sent++;
        end
        serve_item();
        find_item(pick_key());
        random_sent += 2;
      end else begin
        mixed_run(20);
      end
    end

    start = 1'b0;
    while (replies_due != 0) @(negedge clk);
    repeat (QUEUE_DEPTH + 4) @(negedge clk);

    $display("items: %0d register, %0d serve, %0d find, %0d ignored; %0d results checked",
             sent_by_action[ACT_REGISTER], sent_by_action[ACT_SERVE],
             sent_by_action[ACT_FIND], sent_by_action[ACT_IGNORED], replies_checked);
    $display("covered full and empty queue, strings cut at zero, hits and misses; next ticket %0d",
             ticket_next);
    if (mismatch_count == 0 && replies_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
